// ===== design/ira_pkg.sv =====
// ira_pkg: shared field widths for the interval resource allocator.
// No dependencies; the interfaces and the allocator module import it.
package ira_pkg;

  localparam int unsigned TIME_W = 24;  // start and end time
  localparam int unsigned TAG_W  = 16;  // item tag
  localparam int unsigned OUT_W  = 11;  // resource number and open count on the result

endpackage

// ===== design/ira_if.sv =====
// ira_req_if / ira_rsp_if: valid-ready channels for requests and results.
// Depends on ira_pkg for the field widths.
interface ira_req_if;
  import ira_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic [TAG_W-1:0]  item_tag;
  logic              last_of_set;

  modport source (output valid, start_time, end_time, item_tag, last_of_set, input ready);
  modport sink   (input valid, start_time, end_time, item_tag, last_of_set, output ready);
endinterface

interface ira_rsp_if;
  import ira_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] tag_out;
  logic [OUT_W-1:0] resource_number;
  logic [OUT_W-1:0] resources_open;
  logic             overflow;

  modport source (output valid, tag_out, resource_number, resources_open, overflow,
                  input ready);
  modport sink   (input valid, tag_out, resource_number, resources_open, overflow,
                  output ready);
endinterface

// ===== design/ira_heap_ram.sv =====
// ira_heap_ram: heap storage, one write port and two registered read ports.
// Read-first on a same-address write. No package dependencies.
module ira_heap_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 35
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== design/interval_resource_allocator.sv =====
// interval_resource_allocator: greedy interval partitioning over a min-heap
// of (end time, resource) pairs held in ira_heap_ram.
// Depends on ira_pkg, ira_if.sv (ira_req_if, ira_rsp_if) and ira_heap_ram.
//
//   channel | dir | payload                                              | handshake
//   --------+-----+------------------------------------------------------+-------------
//   req     | in  | start_time, end_time, item_tag, last_of_set          | valid/ready
//   rsp     | out | tag_out, resource_number, resources_open, overflow   | valid/ready
//
// Sequence: one request at a time. A request goes from accept to the result
//   register through accept, root check, one step per heap level the new
//   entry moves (at most log2 of the heap count, 10 for 1024 entries; sift-up
//   reads the parent on port a, sift-down both children on two RAM ports),
//   final write and hand-off, with one more compare step when the entry stops
//   short of the root (push) or of a leaf (reuse). Overflow goes from the root
//   check straight to hand-off.
// Reset: rst (synchronous) empties the heap by clearing the count; RAM
//   contents are never cleared, only entries below the count are used.
// Stalls: a finished result parks in the output register; the next request
//   is taken while it waits. The engine holds in its hand-off state only when
//   the output register is still full.
module interval_resource_allocator #(
  parameter int unsigned HEAP_DEPTH = 1024
) (
  input logic clk,
  input logic rst,
  ira_req_if.sink   req,
  ira_rsp_if.source rsp
);
  import ira_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_DEPTH);      // heap index
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);  // count and resource number
  localparam int unsigned XW = AW + 2;                  // child index arithmetic
  localparam int unsigned SW = TIME_W + CW;

  typedef struct packed {
    logic [TIME_W-1:0] end_t;
    logic [CW-1:0]     res;
  } slot_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_UP    = 6'b000100,
    S_DOWN  = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Heap order: earlier end first, lower resource number on a tie.
  function automatic logic slot_less(input slot_t a, input slot_t b);
    return (a.end_t < b.end_t) || ((a.end_t == b.end_t) && (a.res < b.res));
  endfunction

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] x);
    return AW'((x - AW'(1)) >> 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;        // live heap entries
  logic [AW-1:0]     pos, pos_next;        // hole being moved through the heap
  slot_t             cur, cur_next;        // entry looking for its place
  logic [CW-1:0]     res_sel, res_sel_next;
  logic              ovf, ovf_next;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] fin_r;
  logic [TAG_W-1:0]  tag_r;
  logic              last_r;

  logic              out_valid;
  logic [TAG_W-1:0]  out_tag;
  logic [OUT_W-1:0]  out_res;
  logic [OUT_W-1:0]  out_open;
  logic              out_ovf;

  // RAM side
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  slot_t             wr_data;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;
  logic [SW-1:0]     rd_data_a, rd_data_b;
  slot_t             slot_a, slot_b;

  logic              accept;
  logic              load_out;

  // Sift-down helpers
  logic [XW-1:0]     lchild, rchild, nl;
  logic              use_b;
  slot_t             csel;
  logic [AW-1:0]     cpos;
  logic [AW-1:0]     ppos;

  assign slot_a = rd_data_a;
  assign slot_b = rd_data_b;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  ira_heap_ram #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (SW)
  ) u_heap (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Child positions of the current hole; the right child only counts when it
  // lies below the heap count.
  assign lchild = {1'b0, pos, 1'b1};
  assign rchild = XW'(lchild + XW'(1));
  assign use_b  = (rchild < XW'(cnt)) && slot_less(slot_b, slot_a);
  assign csel   = use_b ? slot_b : slot_a;
  assign cpos   = use_b ? rchild[AW-1:0] : lchild[AW-1:0];
  assign nl     = {1'b0, cpos, 1'b1};
  assign ppos   = parent_of(pos);

  // ---------------------------------------------------------------------------
  // Sequencer: root check, then sift up (push) or sift down (reuse)
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    pos_next     = pos;
    cur_next     = cur;
    res_sel_next = res_sel;
    ovf_next     = ovf;
    rd_addr_a    = '0;
    rd_addr_b    = '0;
    wr_en        = 1'b0;
    wr_addr      = pos;
    wr_data      = cur;
    load_out     = 1'b0;

    unique case (state)
      S_IDLE: begin
        // root is read every idle cycle so it is ready in the check state
        if (accept) begin
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        ovf_next = 1'b0;
        if ((cnt == '0) || (slot_a.end_t >= start_r)) begin
          // open a new resource
          if (cnt >= CW'(HEAP_DEPTH)) begin
            ovf_next     = 1'b1;
            res_sel_next = '0;
            state_next   = S_DONE;
          end else begin
            cur_next.end_t = fin_r;
            cur_next.res   = CW'(cnt + CW'(1));
            res_sel_next   = CW'(cnt + CW'(1));
            cnt_next       = CW'(cnt + CW'(1));
            pos_next       = AW'(cnt);
            if (cnt == '0) begin
              state_next = S_PUT;
            end else begin
              rd_addr_a  = parent_of(AW'(cnt));
              state_next = S_UP;
            end
          end
        end else begin
          // reuse the earliest-ending resource: replace the root, sift down
          cur_next.end_t = fin_r;
          cur_next.res   = slot_a.res;
          res_sel_next   = slot_a.res;
          pos_next       = '0;
          if (cnt <= CW'(1)) begin
            state_next = S_PUT;
          end else begin
            rd_addr_a  = AW'(1);
            rd_addr_b  = AW'(2);
            state_next = S_DOWN;
          end
        end
      end

      S_UP: begin
        // parent of pos is on port a
        if (slot_less(cur, slot_a)) begin
          wr_en    = 1'b1;
          wr_addr  = pos;
          wr_data  = slot_a;
          pos_next = ppos;
          if (ppos == '0) begin
            state_next = S_PUT;
          end else begin
            rd_addr_a = parent_of(ppos);
          end
        end else begin
          state_next = S_PUT;
        end
      end

      S_DOWN: begin
        // both children of pos are on ports a and b
        if (slot_less(csel, cur)) begin
          wr_en    = 1'b1;
          wr_addr  = pos;
          wr_data  = csel;
          pos_next = cpos;
          if (nl >= XW'(cnt)) begin
            state_next = S_PUT;
          end else begin
            rd_addr_a = nl[AW-1:0];
            rd_addr_b = AW'(nl + XW'(1));
          end
        end else begin
          state_next = S_PUT;
        end
      end

      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = pos;
        wr_data    = cur;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          if (last_r) begin
            cnt_next = '0;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    cur     <= cur_next;
    res_sel <= res_sel_next;
    ovf     <= ovf_next;
    if (accept) begin
      start_r <= req.start_time;
      fin_r   <= req.end_time;
      tag_r   <= req.item_tag;
      last_r  <= req.last_of_set;
    end
    if (load_out) begin
      out_tag  <= tag_r;
      out_res  <= OUT_W'(res_sel);
      out_open <= OUT_W'(cnt);
      out_ovf  <= ovf;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.tag_out         = out_tag;
  assign rsp.resource_number = out_res;
  assign rsp.resources_open  = out_open;
  assign rsp.overflow        = out_ovf;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_write_live: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) < cnt))
    else $error("heap write outside live entries");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    load_out && ovf |-> (res_sel == '0) && (cnt == CW'(HEAP_DEPTH)))
    else $error("overflow reported with heap not full");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while engine busy");
`endif

endmodule

// ===== bench/tb_interval_resource_allocator.sv =====
`timescale 1ns / 100ps
// tb_interval_resource_allocator: self-checking bench for interval_resource_allocator.
// Depends on ira_pkg, the ira_req_if / ira_rsp_if interfaces and the allocator RTL.
module tb_interval_resource_allocator;
  import ira_pkg::*;

  localparam int unsigned HEAP_DEPTH  = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Extra cycles run after the last result, as a margin for the tail.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TAG_W-1:0]  item_tag;
    logic              last_of_set;
    logic              drain_first;  // hold this request until all results are back
  } interval_req_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag_out;
    logic [OUT_W-1:0] resource_number;
    logic [OUT_W-1:0] resources_open;
    logic             overflow;
  } alloc_result_t;

  logic clk;
  logic rst;

  ira_req_if req_bus ();
  ira_rsp_if rsp_bus ();

  interval_resource_allocator #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a min-heap of (end time, resource) pairs, ties to the lower
  // resource number. Only slots below slot_count are ever read.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] slot_end [HEAP_DEPTH];
  logic [OUT_W-1:0]  slot_res [HEAP_DEPTH];
  int unsigned       slot_count;

  function automatic bit slot_before(int unsigned a, int unsigned b);
    if (slot_end[a] != slot_end[b]) return slot_end[a] < slot_end[b];
    return slot_res[a] < slot_res[b];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [TIME_W-1:0] e;
    logic [OUT_W-1:0]  r;
    e = slot_end[a];
    r = slot_res[a];
    slot_end[a] = slot_end[b];
    slot_res[a] = slot_res[b];
    slot_end[b] = e;
    slot_res[b] = r;
  endfunction

  function automatic alloc_result_t allocate_interval(interval_req_t r);
    alloc_result_t res;
    int unsigned   i;
    int unsigned   k;
    int unsigned   lc;
    int unsigned   pick;
    res = '0;
    res.tag_out = r.item_tag;
    if (slot_count == 0 || slot_end[0] >= r.start_time) begin
      // Earliest-ending resource is still busy: open a new one, if room.
      if (slot_count >= HEAP_DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        k = slot_count;
        slot_end[k] = r.end_time;
        slot_res[k] = OUT_W'(k + 1);
        slot_count = k + 1;
        res.resource_number = OUT_W'(k + 1);
        i = k;
        while (i > 0) begin
          if (!slot_before(i, (i - 1) / 2)) break;
          swap_slots(i, (i - 1) / 2);
          i = (i - 1) / 2;
        end
      end
    end else begin
      // Reuse the top resource: replace its end time and sift down.
      res.resource_number = slot_res[0];
      slot_end[0] = r.end_time;
      i = 0;
      while (1) begin
        lc = 2 * i + 1;
        if (lc >= slot_count) break;
        pick = lc;
        if (lc + 1 < slot_count && slot_before(lc + 1, lc)) pick = lc + 1;
        if (!slot_before(pick, i)) break;
        swap_slots(i, pick);
        i = pick;
      end
    end
    res.resources_open = OUT_W'(slot_count);
    // The last interval of a set empties the heap, overflow or not.
    if (r.last_of_set) slot_count = 0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store and helpers
  // ---------------------------------------------------------------------------
  interval_req_t interval_queue [$];
  alloc_result_t predicted_allocs [$];
  int unsigned   total_requests;
  int unsigned   directed_requests;

  function automatic logic [TIME_W-1:0] clamp_time(longint unsigned v);
    return (v > 64'(TIME_MAX)) ? TIME_MAX : v[TIME_W-1:0];
  endfunction

  function automatic void queue_interval(logic [TIME_W-1:0] st, logic [TIME_W-1:0] en,
                                         logic [TAG_W-1:0] tag, logic last, logic drain);
    interval_req_t r;
    r.start_time  = st;
    r.end_time    = en;
    r.item_tag    = tag;
    r.last_of_set = last;
    r.drain_first = drain;
    interval_queue.push_back(r);
    total_requests++;
  endfunction

  // Build one set of intervals: nondecreasing starts with random steps and
  // spans, sprinkled with out-of-order noise and early set ends.
  function automatic void queue_random_set();
    int unsigned       n;
    int unsigned       span_max;
    int unsigned       step_max;
    longint unsigned   st;
    logic [TIME_W-1:0] s_item;
    logic [TIME_W-1:0] e_item;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
    case ($urandom_range(0, 3))
      0: span_max = 3;
      1: span_max = 64;
      2: span_max = 4096;
      default: span_max = 32'(TIME_MAX);
    endcase
    case ($urandom_range(0, 3))
      0: step_max = 0;
      1: step_max = 1;
      2: step_max = 16;
      default: step_max = 1024;
    endcase
    st = 64'($urandom_range(0, TIME_MAX));
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        s_item = TIME_W'($urandom);
        e_item = TIME_W'($urandom);
      end else begin
        st = 64'(clamp_time(st + 64'($urandom_range(0, step_max))));
        s_item = st[TIME_W-1:0];
        e_item = clamp_time(st + 64'($urandom_range(0, span_max)));
      end
      queue_interval(s_item, e_item, TAG_W'($urandom),
                     (k == n - 1) || ($urandom_range(0, 39) == 0),
                     (k == 0) && ($urandom_range(0, 9) == 0));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps, changes at negedge
  // ---------------------------------------------------------------------------
  bit            req_fire;
  int unsigned   burst_left;
  int unsigned   gap_left;
  int unsigned   drain_pauses;
  interval_req_t next_req;

  always @(negedge clk) begin
    if (rst !== 1'b0) begin
      req_bus.valid <= 1'b0;
    end else if (req_bus.valid && !req_fire) begin
      // hold the request until it is taken
    end else if (gap_left > 0) begin
      req_bus.valid <= 1'b0;
      gap_left--;
    end else if (interval_queue.size() == 0) begin
      req_bus.valid <= 1'b0;
    end else if (interval_queue[0].drain_first && predicted_allocs.size() != 0) begin
      // Drop valid until the block has handed back every result.
      req_bus.valid <= 1'b0;
    end else begin
      next_req = interval_queue.pop_front();
      if (next_req.drain_first) drain_pauses++;
      req_bus.start_time  <= next_req.start_time;
      req_bus.end_time    <= next_req.end_time;
      req_bus.item_tag    <= next_req.item_tag;
      req_bus.last_of_set <= next_req.last_of_set;
      req_bus.valid       <= 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          // Long back-to-back stretch.
          burst_left = 80;
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: ready pattern switches between several stall modes
  // ---------------------------------------------------------------------------
  int unsigned rsp_mode;
  int unsigned mode_left;
  int unsigned stall_left;
  bit          stall_low;
  bit          ready_next;

  always @(negedge clk) begin
    if (rst !== 1'b0) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rsp_mode  = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (rsp_mode)
        0: ready_next = 1'b1;
        1: ready_next = 1'($urandom_range(0, 1));
        2: ready_next = ($urandom_range(0, 7) != 0);
        default: begin
          if (stall_left == 0) begin
            stall_low  = !stall_low;
            stall_left = stall_low ? $urandom_range(1, 25) : $urandom_range(1, 10);
          end else begin
            stall_left--;
          end
          ready_next = !stall_low;
        end
      endcase
      rsp_bus.ready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results first, then predict for the request taken this edge
  // ---------------------------------------------------------------------------
  int unsigned   fail_count;
  int unsigned   results_checked;
  int unsigned   requests_accepted;
  int unsigned   overflow_seen;
  int unsigned   peak_open;
  int unsigned   cycle_count;
  alloc_result_t want;
  interval_req_t taken_req;

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    req_fire = (rst === 1'b0) && (req_bus.valid === 1'b1) && (req_bus.ready === 1'b1);
    if (rst === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (predicted_allocs.size() == 0) begin
        $error("result with no request outstanding: tag_out %0d", rsp_bus.tag_out);
        fail_count++;
      end else begin
        want = predicted_allocs.pop_front();
        check_field("tag_out", 32'(want.tag_out), 32'(rsp_bus.tag_out));
        check_field("resource_number", 32'(want.resource_number),
                    32'(rsp_bus.resource_number));
        check_field("resources_open", 32'(want.resources_open),
                    32'(rsp_bus.resources_open));
        check_field("overflow", 32'(want.overflow), 32'(rsp_bus.overflow));
        results_checked++;
        if (want.overflow) overflow_seen++;
        if (32'(want.resources_open) > peak_open) peak_open = 32'(want.resources_open);
      end
    end
    if (req_fire) begin
      taken_req.start_time  = req_bus.start_time;
      taken_req.end_time    = req_bus.end_time;
      taken_req.item_tag    = req_bus.item_tag;
      taken_req.last_of_set = req_bus.last_of_set;
      taken_req.drain_first = 1'b0;
      predicted_allocs.push_back(allocate_interval(taken_req));
      requests_accepted++;
    end
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_interval_resource_allocator: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int unsigned     fill_start;
  longint unsigned reuse_start;

  initial begin
    rst                 = 1'b1;
    req_bus.valid       = 1'b0;
    req_bus.start_time  = '0;
    req_bus.end_time    = '0;
    req_bus.item_tag    = '0;
    req_bus.last_of_set = 1'b0;
    rsp_bus.ready       = 1'b0;
    slot_count          = 0;
    burst_left          = 0;
    gap_left            = 0;

    // Directed set: empty heap, equal start and end (busy), tie on end time
    // going to the lower resource, reuse, and set end clearing the heap.
    queue_interval(24'd0, 24'd0, 16'h0000, 1'b0, 1'b0);
    queue_interval(24'd0, TIME_MAX, 16'hFFFF, 1'b0, 1'b0);
    queue_interval(24'd1, 24'd5, 16'h0001, 1'b0, 1'b0);
    queue_interval(24'd5, 24'd5, 16'h0002, 1'b0, 1'b0);
    queue_interval(24'd6, 24'd9, 16'h0003, 1'b0, 1'b0);
    queue_interval(24'd6, 24'd9, 16'h0004, 1'b0, 1'b0);
    queue_interval(24'd10, 24'd10, 16'h0005, 1'b1, 1'b0);
    // Top of the time range, end below start, and broken start order.
    queue_interval(TIME_MAX, TIME_MAX, 16'hAAAA, 1'b0, 1'b0);
    queue_interval(TIME_MAX, 24'd0, 16'h5555, 1'b0, 1'b0);
    queue_interval(TIME_MAX, 24'd7, 16'h00FF, 1'b0, 1'b0);
    queue_interval(24'd3, 24'd2, 16'hFF00, 1'b0, 1'b0);
    queue_interval(24'd0, TIME_MAX, 16'h1234, 1'b1, 1'b0);
    // Single-interval sets: each must start again at resource 1.
    queue_interval(24'h123456, 24'h123455, 16'h8000, 1'b1, 1'b0);
    queue_interval(24'd0, 24'd0, 16'h7FFF, 1'b1, 1'b0);
    // Alternating bit patterns, then a reuse after an out-of-order start.
    queue_interval(24'h555555, 24'hAAAAAA, 16'h5A5A, 1'b0, 1'b0);
    queue_interval(24'hAAAAAA, 24'h555555, 16'hA5A5, 1'b0, 1'b0);
    queue_interval(24'hAAAAAB, 24'hFFFFFE, 16'hC3C3, 1'b0, 1'b0);
    queue_interval(24'h000001, 24'h000001, 16'h3C3C, 1'b1, 1'b0);
    directed_requests = total_requests;

    while (total_requests < directed_requests + 40) queue_random_set();

    // Fill the heap to its depth with overlapping intervals, then hit the
    // full heap with requests that overflow and requests that reuse.
    fill_start = $urandom_range(0, 24'hF00000);
    for (int unsigned k = 0; k < HEAP_DEPTH; k++) begin
      queue_interval(TIME_W'(fill_start), TIME_W'(fill_start + $urandom_range(0, 4095)),
                     TAG_W'($urandom), 1'b0, k == 0);
    end
    for (int unsigned k = 0; k < 3; k++) begin
      queue_interval(TIME_W'(fill_start),
                     clamp_time(64'(fill_start + $urandom_range(0, 9999))),
                     TAG_W'($urandom), 1'b0, 1'b0);
    end
    for (int unsigned k = 0; k < 16; k++) begin
      reuse_start = 64'(fill_start + 5000 + k);
      queue_interval(reuse_start[TIME_W-1:0],
                     clamp_time(reuse_start + 64'($urandom_range(0, 4095))),
                     TAG_W'($urandom), 1'b0, 1'b0);
    end
    // Overflow on the last interval of the set: heap still gets cleared.
    queue_interval(TIME_W'(fill_start), TIME_MAX, TAG_W'($urandom), 1'b1, 1'b1);

    while (total_requests < directed_requests + 1130) queue_random_set();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (requests_accepted < total_requests || predicted_allocs.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d directed) and %0d checked results.",
             requests_accepted, directed_requests, results_checked);
    $display("Peak open resources %0d, overflow results %0d, drain pauses %0d.",
             peak_open, overflow_seen, drain_pauses);
    if (fail_count == 0) begin
      $display("tb_interval_resource_allocator: PASS");
    end else begin
      $display("tb_interval_resource_allocator: FAIL");
    end
    $finish;
  end

endmodule
